>>> src/assert_macros.svh
// Assertion helpers used by cfap_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> src/cfap_pkg.sv
`timescale 1ns / 1ps
package cfap_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CONV_START,
      ST_CONV_WAIT,
      ST_CONV_EMIT,
      ST_EUC_START,
      ST_EUC_WAIT,
      ST_MUL,
      ST_NB_CALC,
      ST_NB_SQ,
      ST_NB_HEX
   } state_type;

   localparam logic [1:0] KIND_CONV   = 2'd0;
   localparam logic [1:0] KIND_SQUARE = 2'd1;
   localparam logic [1:0] KIND_HEX    = 2'd2;

   localparam logic [3:0]  MAX_TERMS_RESET = 4'd8;
   // sqrt(3)/2 in Q0.32
   localparam logic [31:0] HEX_SCALE = 32'hDDB3D743;

   typedef struct packed {
      logic       load;
      logic       div_start;
      logic       div_euclid;
      logic       mul_start;
      logic       mul_step;
      logic       update;
      logic       nb_calc;
      logic       nb_next;
      logic       emit;
      logic [1:0] emit_kind;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic mul_done;
      logic num_zero;
      logic nb_end;
      logic out_free;
   } status_type;

endpackage

>>> src/cfap_req_if.sv
`timescale 1ns / 1ps
interface cfap_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_real;
   logic signed [31:0] point_imag;

   modport source (output valid, output point_real, output point_imag, input ready);
   modport sink (input valid, input point_real, input point_imag, output ready);
endinterface

>>> src/cfap_rsp_if.sv
`timescale 1ns / 1ps
interface cfap_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] anchor_real;
   logic signed [31:0] anchor_imag;
   logic [1:0]         anchor_kind;
   logic               last_anchor;

   modport source (output valid, output anchor_real, output anchor_imag,
                   output anchor_kind, output last_anchor, input ready);
   modport sink (input valid, input anchor_real, input anchor_imag,
                 input anchor_kind, input last_anchor, output ready);
endinterface

>>> src/cfap_div.sv
`timescale 1ns / 1ps
module cfap_div #(
   parameter int NW = 52,
   parameter int DVW = 18,
   localparam int CW = $clog2(NW + 1)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [CW-1:0]  len,
   input  logic [NW-1:0]  dividend,
   input  logic [DVW-1:0] divisor,
   output logic           busy,
   output logic [NW-1:0]  quotient,
   output logic [DVW-1:0] remainder
);
   logic           busy_ff, busy_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [NW-1:0]  quo_ff, quo_in;
   logic [DVW-1:0] rem_ff, rem_in;
   logic [DVW-1:0] dvs_ff, dvs_in;
   logic [DVW:0]   trial;
   logic [DVW:0]   diff;

   // one quotient bit per cycle, dividend enters MSB first
   always_comb begin
      trial = {rem_ff, quo_ff[NW-1]};
      diff = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = len;
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DVW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DVW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy = busy_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;
endmodule

>>> src/cfap_dp.sv
`timescale 1ns / 1ps
module cfap_dp #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfap_pkg::cmd_type    cmd,
   output cfap_pkg::status_type status,
   input  logic signed [31:0]   point_real,
   input  logic signed [31:0]   point_imag,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic signed [31:0]   anchor_real,
   output logic signed [31:0]   anchor_imag,
   output logic [1:0]           anchor_kind,
   output logic                 last_anchor
);
   import cfap_pkg::*;

   localparam int FB  = FRACTION_BITS;
   localparam int IW  = 32 - FB;
   localparam int PW  = 35;
   localparam int QW  = FB + 1;
   localparam int NW  = PW + FB + 1;
   localparam int DVW = FB + 2;
   localparam int GW  = IW + 3;
   localparam int PRW = GW + 32;
   localparam int CW  = $clog2(NW + 1);
   localparam logic signed [39:0] S_MAX = 40'sd2147483647;
   localparam logic signed [39:0] S_MIN = -40'sd2147483648;

   function automatic logic [31:0] sat_fn(input logic signed [39:0] v);
      logic [31:0] r;
      if (v > S_MAX) r = 32'h7FFFFFFF;
      else if (v < S_MIN) r = 32'h80000000;
      else r = v[31:0];
      return r;
   endfunction

   // round half away from zero to an integer
   function automatic logic signed [GW-1:0] round_fn(input logic signed [31:0] x);
      logic signed [32:0] ext;
      logic [32:0]        mag;
      logic [32:0]        sh;
      ext = {x[31], x};
      mag = x[31] ? 33'(-ext) : 33'(ext);
      sh = (mag + (33'(1) << (FB - 1))) >> FB;
      return x[31] ? -GW'(sh) : GW'(sh);
   endfunction

   logic signed [PW-1:0] p_ff, p_in, pp_ff, pp_in;
   logic [QW-1:0]        q_ff, q_in, pq_ff, pq_in;
   logic [QW-1:0]        num_ff, num_in, den_ff, den_in;
   logic [QW-1:0]        a_sh_ff, a_sh_in;
   logic signed [PW-1:0] p_sh_ff, p_sh_in, acc_p_ff, acc_p_in;
   logic [QW-1:0]        q_sh_ff, q_sh_in, acc_q_ff, acc_q_in;
   logic signed [GW-1:0] re_ff, re_in, im_ff, im_in;
   logic signed [1:0]    i_ff, i_in, j_ff, j_in;
   logic [31:0]          sq_re_ff, sq_re_in, sq_im_ff, sq_im_in, hx_re_ff, hx_re_in;
   logic [PRW-1:0]       hx_prod_ff, hx_prod_in;
   logic                 hx_neg_ff, hx_neg_in;
   logic                 valid_ff, valid_in;
   logic [31:0]          out_re_ff, out_re_in, out_im_ff, out_im_in;
   logic [1:0]           kind_ff, kind_in;
   logic                 last_ff, last_in;

   logic signed [31:0]   a0;
   logic [PW-1:0]        p_mag;
   logic                 div_busy;
   logic [NW-1:0]        div_quo, div_dividend;
   logic [DVW-1:0]       div_rem, div_divisor;
   logic [CW-1:0]        div_len;
   logic [31:0]          conv_re;
   logic signed [GW-1:0] gr, gi;
   logic [GW-1:0]        gi_mag;
   logic signed [39:0]   gr_w, gi_w;
   logic [PRW-1:0]       hv;
   logic [33:0]          hv34;
   logic [31:0]          hx_im;
   logic                 out_free;

   assign p_mag = p_ff[PW-1] ? PW'(-p_ff) : PW'(p_ff);
   assign div_dividend = cmd.div_euclid ? {den_ff, {(NW - QW){1'b0}}}
                                        : {p_mag, {(FB + 1){1'b0}}} + NW'(q_ff);
   assign div_divisor = cmd.div_euclid ? {1'b0, num_ff} : {q_ff, 1'b0};
   assign div_len = cmd.div_euclid ? CW'(QW) : CW'(NW);

   cfap_div #(.NW(NW), .DVW(DVW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .len       (div_len),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      // convergent p/q, saturated
      if (!p_ff[PW-1]) begin
         conv_re = (div_quo > NW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : div_quo[31:0];
      end else begin
         conv_re = (div_quo > NW'(33'h080000000)) ? 32'h80000000
                                                  : (~div_quo[31:0] + 32'd1);
      end
      a0 = point_real >>> FB;
      gr = re_ff + GW'(i_ff);
      gi = im_ff + GW'(j_ff);
      gi_mag = gi[GW-1] ? GW'(-gi) : GW'(gi);
      gr_w = 40'(gr);
      gi_w = 40'(gi);
      hv = (hx_prod_ff + (PRW'(1) << (IW - 1))) >> IW;
      hv34 = hv[33:0];
      hx_im = hx_neg_ff ? sat_fn(-40'(hv34)) : sat_fn(40'(hv34));
      out_free = !valid_ff || rsp_ready;

      p_in = p_ff;
      pp_in = pp_ff;
      q_in = q_ff;
      pq_in = pq_ff;
      num_in = num_ff;
      den_in = den_ff;
      a_sh_in = a_sh_ff;
      p_sh_in = p_sh_ff;
      q_sh_in = q_sh_ff;
      acc_p_in = acc_p_ff;
      acc_q_in = acc_q_ff;
      re_in = re_ff;
      im_in = im_ff;
      i_in = i_ff;
      j_in = j_ff;
      sq_re_in = sq_re_ff;
      sq_im_in = sq_im_ff;
      hx_re_in = hx_re_ff;
      hx_prod_in = hx_prod_ff;
      hx_neg_in = hx_neg_ff;
      out_re_in = out_re_ff;
      out_im_in = out_im_ff;
      kind_in = kind_ff;
      last_in = last_ff;
      valid_in = valid_ff && !rsp_ready;

      if (cmd.load) begin
         p_in = PW'(a0);
         q_in = QW'(1);
         pp_in = PW'(1);
         pq_in = '0;
         num_in = {1'b0, point_real[FB-1:0]};
         den_in = QW'(1) << FB;
         re_in = round_fn(point_real);
         im_in = round_fn(point_imag);
         i_in = -2'sd1;
         j_in = -2'sd1;
      end
      if (cmd.mul_start) begin
         a_sh_in = div_quo[QW-1:0];
         p_sh_in = p_ff;
         q_sh_in = q_ff;
         acc_p_in = pp_ff;
         acc_q_in = pq_ff;
      end
      if (cmd.mul_step) begin
         if (a_sh_ff[0]) begin
            acc_p_in = acc_p_ff + p_sh_ff;
            acc_q_in = acc_q_ff + q_sh_ff;
         end
         a_sh_in = a_sh_ff >> 1;
         p_sh_in = p_sh_ff <<< 1;
         q_sh_in = q_sh_ff << 1;
      end
      if (cmd.update) begin
         pp_in = p_ff;
         pq_in = q_ff;
         p_in = acc_p_ff;
         q_in = acc_q_ff;
         den_in = num_ff;
         num_in = div_rem[QW-1:0];
      end
      if (cmd.nb_calc) begin
         sq_re_in = sat_fn(gr_w <<< FB);
         sq_im_in = sat_fn(gi_w <<< FB);
         hx_re_in = sat_fn((gr_w <<< FB) + (gi_w <<< (FB - 1)));
         hx_prod_in = PRW'(gi_mag) * PRW'(HEX_SCALE);
         hx_neg_in = gi[GW-1];
      end
      if (cmd.nb_next) begin
         if (j_ff == 2'sd1) begin
            j_in = -2'sd1;
            i_in = i_ff + 2'sd1;
         end else begin
            j_in = j_ff + 2'sd1;
         end
      end
      if (cmd.emit) begin
         valid_in = 1'b1;
         kind_in = cmd.emit_kind;
         last_in = cmd.emit_last;
         case (cmd.emit_kind)
            KIND_SQUARE: begin
               out_re_in = sq_re_ff;
               out_im_in = sq_im_ff;
            end
            KIND_HEX: begin
               out_re_in = hx_re_ff;
               out_im_in = hx_im;
            end
            default: begin
               out_re_in = conv_re;
               out_im_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      pp_ff <= pp_in;
      q_ff <= q_in;
      pq_ff <= pq_in;
      num_ff <= num_in;
      den_ff <= den_in;
      a_sh_ff <= a_sh_in;
      p_sh_ff <= p_sh_in;
      q_sh_ff <= q_sh_in;
      acc_p_ff <= acc_p_in;
      acc_q_ff <= acc_q_in;
      re_ff <= re_in;
      im_ff <= im_in;
      i_ff <= i_in;
      j_ff <= j_in;
      sq_re_ff <= sq_re_in;
      sq_im_ff <= sq_im_in;
      hx_re_ff <= hx_re_in;
      hx_prod_ff <= hx_prod_in;
      hx_neg_ff <= hx_neg_in;
      out_re_ff <= out_re_in;
      out_im_ff <= out_im_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   assign status.div_busy = div_busy;
   assign status.mul_done = (a_sh_ff == '0);
   assign status.num_zero = (num_ff == '0);
   assign status.nb_end = (i_ff == 2'sd1) && (j_ff == 2'sd1);
   assign status.out_free = out_free;

   assign rsp_valid = valid_ff;
   assign anchor_real = out_re_ff;
   assign anchor_imag = out_im_ff;
   assign anchor_kind = kind_ff;
   assign last_anchor = last_ff;
endmodule

>>> src/cfap_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cfap_ctrl #(
   parameter int TERM_LIMIT = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 csr_we,
   input  logic [3:0]           csr_wdata,
   input  cfap_pkg::status_type status,
   output cfap_pkg::cmd_type    cmd
);
   import cfap_pkg::*;

   localparam int TCW = $clog2(TERM_LIMIT + 1);

   state_type      state_ff, state_in;
   logic [3:0]     max_terms_ff, max_terms_in;
   logic [TCW-1:0] t_ff, t_in;
   logic           more_terms;
   logic           req_accept;

   assign more_terms = (32'(t_ff) < 32'(max_terms_ff)) && (32'(t_ff) < TERM_LIMIT);
   assign req_accept = req_valid && req_ready;
   assign max_terms_in = csr_we ? csr_wdata : max_terms_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      t_in = t_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               t_in = '0;
               state_in = ST_CONV_START;
            end
         end
         ST_CONV_START: begin
            cmd.div_start = 1'b1;
            state_in = ST_CONV_WAIT;
         end
         ST_CONV_WAIT: begin
            if (!status.div_busy) state_in = ST_CONV_EMIT;
         end
         ST_CONV_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.emit_kind = KIND_CONV;
               state_in = (more_terms && !status.num_zero) ? ST_EUC_START : ST_NB_CALC;
            end
         end
         ST_EUC_START: begin
            cmd.div_start = 1'b1;
            cmd.div_euclid = 1'b1;
            state_in = ST_EUC_WAIT;
         end
         ST_EUC_WAIT: begin
            if (!status.div_busy) begin
               cmd.mul_start = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // shift-add a*p and a*q, then advance the convergent
            if (status.mul_done) begin
               cmd.update = 1'b1;
               t_in = t_ff + TCW'(1);
               state_in = ST_CONV_START;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         ST_NB_CALC: begin
            cmd.nb_calc = 1'b1;
            state_in = ST_NB_SQ;
         end
         ST_NB_SQ: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.emit_kind = KIND_SQUARE;
               state_in = ST_NB_HEX;
            end
         end
         ST_NB_HEX: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.emit_kind = KIND_HEX;
               cmd.emit_last = status.nb_end;
               if (status.nb_end) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.nb_next = 1'b1;
                  state_in = ST_NB_CALC;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         max_terms_ff <= MAX_TERMS_RESET;
         t_ff <= '0;
      end else begin
         state_ff <= state_in;
         max_terms_ff <= max_terms_in;
         t_ff <= t_in;
      end
   end

   `ASSERT_IMPLIES(a_div_start_idle, clock, reset, cmd.div_start, !status.div_busy)
   `ASSERT_IMPLIES(a_emit_slot_free, clock, reset, cmd.emit, status.out_free)
   `ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_accept, state_ff != ST_IDLE)
endmodule

>>> src/continued_fraction_anchor_points_top.sv
`timescale 1ns / 1ps
// Continued-fraction anchor points. Each request carries a Q16.16 complex point
// and yields a run of anchors: the convergents of the real part (kind 0), then a
// square (kind 1) and a hex (kind 2) point for each of the nine integer
// neighbours, last_anchor marking the end. One request is worked at a time.
// A shared one-bit-per-cycle divider sets the rate: each convergent takes one
// NW-bit division (NW = FRACTION_BITS+36, 52 by default), each further partial
// quotient adds a Euclid division and a shift-add multiply, and the nine
// neighbours follow. max_terms is written through csr_we/csr_wdata; the user
// must write it only while the block is idle; the block does not enforce this.
module continued_fraction_anchor_points_top #(
   parameter int TERM_LIMIT = 8,
   parameter int FRACTION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   cfap_req_if.sink          req_chan,
   cfap_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  logic [3:0]        csr_wdata
);
   import cfap_pkg::*;

   cmd_type    cmd;
   status_type status;

   cfap_ctrl #(.TERM_LIMIT(TERM_LIMIT)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .status    (status),
      .cmd       (cmd)
   );

   cfap_dp #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .point_real  (req_chan.point_real),
      .point_imag  (req_chan.point_imag),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .anchor_real (rsp_chan.anchor_real),
      .anchor_imag (rsp_chan.anchor_imag),
      .anchor_kind (rsp_chan.anchor_kind),
      .last_anchor (rsp_chan.last_anchor)
   );
endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import cfap_pkg::*;

   typedef enum logic [1:0] {OP_POINT, OP_CFG, OP_DRAIN} op_type;

   typedef struct {
      op_type      op;
      logic [31:0] re;
      logic [31:0] im;
      logic [3:0]  terms;
   } pending_type;

   typedef struct {
      logic [31:0] re;
      logic [31:0] im;
      logic [1:0]  kind;
      logic        last;
   } anchor_type;

   localparam int  FRAC = 16;
   localparam longint ONE = 64'sd1 << FRAC;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [3:0] csr_wdata = 4'd0;

   cfap_req_if req_bus ();
   cfap_rsp_if rsp_bus ();

   continued_fraction_anchor_points_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   pending_type pending_q[$];
   anchor_type  anchor_q[$];
   logic [3:0]  terms_shadow = MAX_TERMS_RESET;
   int          errors = 0;
   bit          no_idle = 0;
   int          req_gap = 0;
   int          rsp_gap = 0;
   int          settle = 0;
   logic        rsp_ready = 1'b0;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.point_real = '0;
      req_bus.point_imag = '0;
      rsp_bus.ready = 1'b0;
   end

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [31:0] sat32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic longint round_half_away(longint x);
      longint half;
      half = ONE / 2;
      if (x >= 0) return (x + half) >>> FRAC;
      return -((-x + half) >>> FRAC);
   endfunction

   function automatic longint fixed_ratio(longint p, longint q);
      longint m, v;
      m = (p < 0 ? -p : p) << FRAC;
      v = (2 * m + q) / (2 * q);
      return p < 0 ? -v : v;
   endfunction

   function automatic longint hex_height(longint k);
      longint mag, v;
      mag = (k < 0 ? -k : k) * longint'({32'd0, HEX_SCALE});
      v = (mag + (64'sd1 << (31 - FRAC))) >>> (32 - FRAC);
      return k < 0 ? -v : v;
   endfunction

   function automatic void push_anchor(longint re, longint im, logic [1:0] kind);
      anchor_type a;
      a.re = sat32(re);
      a.im = sat32(im);
      a.kind = kind;
      a.last = 1'b0;
      anchor_q.insert(anchor_q.size(), a);
   endfunction

   function automatic void predict_anchors(logic signed [31:0] pr, logic signed [31:0] pi);
      longint x, y, a0, num, den, r, a, pp, pq, p, q, np, nq, rr, ri, gr, gi;
      int limit;
      x = pr;
      y = pi;
      limit = terms_shadow > 8 ? 8 : terms_shadow;
      a0 = x >>> FRAC;
      num = x - a0 * ONE;
      den = ONE;
      pp = 1; pq = 0; p = a0; q = 1;
      push_anchor(fixed_ratio(p, q), 0, KIND_CONV);
      for (int t = 0; t < limit && num != 0; t++) begin
         a = den / num;
         r = den % num;
         np = a * p + pp;
         nq = a * q + pq;
         den = num; num = r;
         pp = p; pq = q; p = np; q = nq;
         push_anchor(fixed_ratio(p, q), 0, KIND_CONV);
      end
      rr = round_half_away(x);
      ri = round_half_away(y);
      for (int i = -1; i <= 1; i++) begin
         for (int j = -1; j <= 1; j++) begin
            gr = rr + i;
            gi = ri + j;
            push_anchor(gr * ONE, gi * ONE, KIND_SQUARE);
            push_anchor(gr * ONE + gi * (ONE / 2), hex_height(gi), KIND_HEX);
         end
      end
      anchor_q[$].last = 1'b1;
   endfunction

   // request driver
   always @(posedge clock) begin
      logic nv, we;
      if (reset) begin
         req_bus.valid <= 1'b0;
         csr_we <= 1'b0;
      end else begin
         nv = req_bus.valid;
         we = 1'b0;
         if (req_bus.valid && req_bus.ready) begin
            predict_anchors(req_bus.point_real, req_bus.point_imag);
            void'(pending_q.pop_front());
            nv = 1'b0;
         end
         if (!nv && pending_q.size() > 0) begin
            if (req_gap > 0) begin
               req_gap--;
            end else begin
               case (pending_q[0].op)
                  OP_POINT: begin
                     if (!no_idle && $urandom_range(0, 5) == 0) begin
                        req_gap = $urandom_range(0, 16);
                     end else begin
                        nv = 1'b1;
                        req_bus.point_real <= pending_q[0].re;
                        req_bus.point_imag <= pending_q[0].im;
                     end
                  end
                  OP_CFG: begin
                     // hold until the block has gone quiet
                     if (anchor_q.size() == 0 && settle >= 40) begin
                        we = 1'b1;
                        csr_wdata <= pending_q[0].terms;
                        terms_shadow = pending_q[0].terms;
                        void'(pending_q.pop_front());
                     end
                  end
                  default: begin
                     if (anchor_q.size() == 0) void'(pending_q.pop_front());
                  end
               endcase
            end
         end
         settle = (anchor_q.size() == 0 && !nv) ? settle + 1 : 0;
         req_bus.valid <= nv;
         csr_we <= we;
      end
   end

   // result monitor
   always @(posedge clock) begin
      anchor_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_ready) begin
            if (anchor_q.size() == 0) begin
               errors++;
               $error("unexpected anchor re=%h im=%h", rsp_bus.anchor_real,
                      rsp_bus.anchor_imag);
            end else begin
               e = anchor_q.pop_front();
               if (rsp_bus.anchor_real !== e.re) begin
                  errors++;
                  $error("anchor_real exp %h got %h", e.re, rsp_bus.anchor_real);
               end
               if (rsp_bus.anchor_imag !== e.im) begin
                  errors++;
                  $error("anchor_imag exp %h got %h", e.im, rsp_bus.anchor_imag);
               end
               if (rsp_bus.anchor_kind !== e.kind) begin
                  errors++;
                  $error("anchor_kind exp %0d got %0d", e.kind, rsp_bus.anchor_kind);
               end
               if (rsp_bus.last_anchor !== e.last) begin
                  errors++;
                  $error("last_anchor exp %0d got %0d", e.last, rsp_bus.last_anchor);
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
            rsp_bus.ready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(0, 16);
            rsp_ready <= 1'b0;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic void add_point(logic [31:0] re, logic [31:0] im);
      pending_type t;
      t.op = OP_POINT; t.re = re; t.im = im; t.terms = '0;
      pending_q.insert(pending_q.size(), t);
   endfunction

   function automatic void add_cfg(logic [3:0] v);
      pending_type t;
      t.op = OP_CFG; t.re = '0; t.im = '0; t.terms = v;
      pending_q.insert(pending_q.size(), t);
   endfunction

   function automatic void add_drain();
      pending_type t;
      t.op = OP_DRAIN; t.re = '0; t.im = '0; t.terms = '0;
      pending_q.insert(pending_q.size(), t);
   endfunction

   function automatic logic [31:0] rand_point();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
         2: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
         default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      endcase
   endfunction

   initial begin
      // directed: extremes, exact halves, long expansions
      add_point(32'h0000_0000, 32'h0000_0000);
      add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_point(32'h8000_0000, 32'h8000_0000);
      add_point(32'h7FFF_FFFF, 32'h8000_0000);
      add_point(32'h0001_8000, 32'hFFFE_8000);
      add_point(32'hFFFE_8000, 32'h0000_8000);
      add_point(32'h0000_5555, 32'hFFFF_7FFF);
      add_point(32'h0003_243F, 32'h0001_0000);
      add_point(32'h0001_9E37, 32'hFFFF_FFFF);
      add_point(32'hFFFF_FFFF, 32'h0000_0001);
      add_point(32'h0000_0001, 32'hFFFF_8000);
      add_point(32'h8000_0001, 32'h7FFF_8000);
      add_drain();
      add_cfg(4'd0);
      add_point(32'h0003_243F, 32'h0002_0000);
      add_point(32'hFFFC_DBC1, 32'h7FFF_FFFF);
      add_cfg(4'd15);
      add_point(32'h0000_5A82, 32'h8000_0000);
      add_point(32'h0003_243F, 32'h0000_0000);
      add_cfg(4'd1);
      add_point(32'h0001_9E37, 32'h0000_0000);
      add_cfg(4'd9);
      add_point(32'h0000_0001, 32'h0000_0000);
      add_cfg(4'd8);
      for (int n = 0; n < 210; n++) begin
         if (n % 40 == 39) add_cfg(4'($urandom_range(0, 15)));
         if (n == 100) add_drain();
         add_point(rand_point(), rand_point());
      end
      add_cfg(4'd8);
      repeat (3) @(negedge clock);
      reset = 1'b0;
      wait (pending_q.size() < 25);
      no_idle = 1;
      while (pending_q.size() > 0 || req_bus.valid || anchor_q.size() > 0)
         @(posedge clock);
      repeat (900) @(posedge clock);
      if (errors == 0 && anchor_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
